>>> rtl/i8mm_pkg.sv
// Shared types, constants and field widths for the int8 matrix multiply block.
package i8mm_pkg;

  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_MAX_COLS  = 64;
  localparam int DEF_MAX_DEPTH = 256;

  localparam int CMD_W   = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int DIDX_W  = 8;
  localparam int ELEM_W  = 8;
  localparam int DOT_W   = 24;
  localparam int DCFG_W  = 9;
  localparam int PROD_W  = 2 * ELEM_W;

  localparam int LANES   = 4;
  localparam int LANE_W  = 2;
  localparam int SUM_W   = PROD_W + LANE_W;

  localparam logic [DCFG_W-1:0] DEPTH_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic req_empty;
    logic last_word;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/i8mm_ctrl.sv
// Controller state machine: decodes transactions and sequences the dot-product walk.
module i8mm_ctrl import i8mm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_stall,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_command)
            CMD_WR_A: cmd.wr_a = 1'b1;
            CMD_WR_B: cmd.wr_b = 1'b1;
            CMD_COMPUTE: begin
              cmd.start = 1'b1;
              state_nxt = status.req_empty ? ST_FINISH : ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.last_word) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/i8mm_datapath.sv
// Datapath: banked operand memories, four-lane multiply-accumulate and result register.
module i8mm_datapath import i8mm_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [DCFG_W-1:0]        cfg_data,
  input  logic [ROW_W-1:0]         in_row_index,
  input  logic [COL_W-1:0]         in_col_index,
  input  logic [DIDX_W-1:0]        in_depth_index,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DOT_W-1:0]  out_dot_value,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col
);

  localparam int WPR     = (MAX_DEPTH + LANES - 1) / LANES;
  localparam int WW      = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int A_DEPTH = MAX_ROWS * WPR;
  localparam int B_DEPTH = MAX_COLS * WPR;
  localparam int AAW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int BAW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int NW      = $clog2(MAX_DEPTH + 1);

  logic [DCFG_W-1:0]        cfg_depth_r;
  logic [NW-1:0]            n_eff;
  logic                     req_in_range;
  logic [WW-1:0]            word_r;
  logic [WW-1:0]            last_word_r;
  logic [AAW-1:0]           a_base_r;
  logic [BAW-1:0]           b_base_r;
  logic [AAW-1:0]           a_rd_addr;
  logic [BAW-1:0]           b_rd_addr;
  logic [AAW-1:0]           a_wr_addr;
  logic [BAW-1:0]           b_wr_addr;
  logic                     a_wr_ok;
  logic                     b_wr_ok;
  logic [ROW_W-1:0]         req_row_r;
  logic [COL_W-1:0]         req_col_r;
  logic [LANES-1:0]         mask_issue;
  logic [LANES-1:0]         mask1_r;
  logic                     v1_r;
  logic                     v2_r;
  logic signed [ELEM_W-1:0] a_rd [LANES];
  logic signed [ELEM_W-1:0] b_rd [LANES];
  logic signed [PROD_W-1:0] prod_r [LANES];
  logic signed [SUM_W-1:0]  lane_sum;
  logic signed [DOT_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic signed [DOT_W-1:0]  out_dot_r;
  logic [ROW_W-1:0]         out_row_r;
  logic [COL_W-1:0]         out_col_r;
  logic [31:0]              a_wr_full;
  logic [31:0]              b_wr_full;
  logic [31:0]              a_base_full;
  logic [31:0]              b_base_full;
  logic [31:0]              last_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_depth_r <= DEPTH_RESET;
    end else if (cfg_we) begin
      cfg_depth_r <= cfg_data;
    end
  end

  always_comb begin
    n_eff = (32'(cfg_depth_r) > MAX_DEPTH) ? NW'(MAX_DEPTH) : NW'(cfg_depth_r);
    req_in_range = (32'(in_row_index) < MAX_ROWS) && (32'(in_col_index) < MAX_COLS);
    a_wr_ok = (32'(in_row_index) < MAX_ROWS) && (32'(in_depth_index) < MAX_DEPTH);
    b_wr_ok = (32'(in_col_index) < MAX_COLS) && (32'(in_depth_index) < MAX_DEPTH);
    a_wr_full   = 32'(in_row_index) * 32'(WPR) + 32'(in_depth_index >> LANE_W);
    b_wr_full   = 32'(in_col_index) * 32'(WPR) + 32'(in_depth_index >> LANE_W);
    a_base_full = 32'(in_row_index) * 32'(WPR);
    b_base_full = 32'(in_col_index) * 32'(WPR);
    last_full   = (32'(n_eff) - 32'd1) >> LANE_W;
    a_wr_addr = a_wr_full[AAW-1:0];
    b_wr_addr = b_wr_full[BAW-1:0];
    a_rd_addr = a_base_r + AAW'(word_r);
    b_rd_addr = b_base_r + BAW'(word_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      word_r      <= '0;
      last_word_r <= last_full[WW-1:0];
      a_base_r    <= a_base_full[AAW-1:0];
      b_base_r    <= b_base_full[BAW-1:0];
      req_row_r   <= in_row_index;
      req_col_r   <= in_col_index;
    end else if (cmd.issue) begin
      word_r <= word_r + 1'b1;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [ELEM_W-1:0] a_mem [A_DEPTH];
    logic signed [ELEM_W-1:0] b_mem [B_DEPTH];

    assign mask_issue[l] = 32'({word_r, LANE_W'(l)}) < 32'(n_eff);

    always_ff @(posedge clk) begin
      if (cmd.wr_a && a_wr_ok && (in_depth_index[LANE_W-1:0] == LANE_W'(l))) begin
        a_mem[a_wr_addr] <= in_element_value;
      end
      a_rd[l] <= a_mem[a_rd_addr];
    end

    always_ff @(posedge clk) begin
      if (cmd.wr_b && b_wr_ok && (in_depth_index[LANE_W-1:0] == LANE_W'(l))) begin
        b_mem[b_wr_addr] <= in_element_value;
      end
      b_rd[l] <= b_mem[b_rd_addr];
    end

    always_ff @(posedge clk) begin
      if (mask1_r[l]) begin
        prod_r[l] <= a_rd[l] * b_rd[l];
      end else begin
        prod_r[l] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mask1_r <= mask_issue;
  end

  always_comb begin
    lane_sum = '0;
    for (int l = 0; l < LANES; l++) begin
      lane_sum = lane_sum + SUM_W'(prod_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + DOT_W'(lane_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_dot_r <= acc_r;
      out_row_r <= req_row_r;
      out_col_r <= req_col_r;
    end
  end

  assign status.req_empty = !req_in_range || (n_eff == '0);
  assign status.last_word = (word_r == last_word_r);
  assign status.pipe_busy = v1_r || v2_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_dot_value = out_dot_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;

  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(v1_r || v2_r))
    else $error("result loaded while products still in flight");

  a_no_write_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_a || cmd.wr_b) |-> !cmd.issue)
    else $error("operand write during dot-product walk");

  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (word_r <= last_word_r))
    else $error("word counter beyond last word");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

>>> rtl/int8_matrix_multiply.sv
// Top level of the int8 matrix multiply block: controller plus datapath.
// Operands A (row-major) and B (column-major) sit in four depth-interleaved byte banks
// each; write transactions of either operand are taken back to back while idle. A
// compute transaction walks the requested row of A and column of B four depth positions
// per cycle through one four-lane multiply-accumulate unit, over n = min(depth_in_use,
// MAX_DEPTH) positions; an out-of-range request or a depth of zero skips the walk. The
// result is loaded once the products have drained and no previous result still sits
// stalled in the output register, and the next transaction is taken in the cycle after
// the load. The input stalls from the acceptance of a compute until that load; a
// finished result waits in the output register while writes go on.
// Operand storage has no reset: every entry summed over must have been written first.
// depth_in_use resets to 256.
module int8_matrix_multiply import i8mm_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [DCFG_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [ROW_W-1:0]         in_row_index,
  input  logic [COL_W-1:0]         in_col_index,
  input  logic [DIDX_W-1:0]        in_depth_index,
  input  logic signed [ELEM_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DOT_W-1:0]  out_dot_value,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col
);

  dp_cmd_t    cmd;
  dp_status_t status;

  i8mm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  i8mm_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_depth_index   (in_depth_index),
    .in_element_value (in_element_value),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dot_value    (out_dot_value),
    .out_row          (out_row),
    .out_col          (out_col)
  );

endmodule
